// ===== hw/rtl/rcpp_pkg.sv =====
// ----------------------------------------------------------------------------
// rcpp_pkg: RTCP compound packet parser shared types and constants
// Header check codes, parse phases, walk state and result item layout.
// ----------------------------------------------------------------------------
`default_nettype none

package rcpp_pkg;

  localparam logic [10:0] MAX_PACKET_BYTES = 11'd1460;
  localparam logic [7:0]  OVERHEAD_RESET   = 8'd28;

  localparam logic [7:0]  PT_SR   = 8'd200;
  localparam logic [7:0]  PT_SDES = 8'd202;

  // first header: version 2, no padding, type SR or RR (bit 16 ignored)
  localparam logic [31:0] HDR_FIRST_MASK = 32'hE0FE_0000;
  localparam logic [31:0] HDR_FIRST_VAL  = 32'h80C8_0000;
  localparam logic [31:0] HDR_VER_MASK   = 32'hC000_0000;
  localparam logic [31:0] HDR_VER_VAL    = 32'h8000_0000;

  // sender info after the SR sender SSRC: NTP pair, RTP stamp, two counts
  localparam logic [17:0] SR_INFO_BYTES  = 18'd20;

  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = 2;

  typedef enum logic [3:0] {
    PH_HEADER    = 4'd0,
    PH_SR_SSRC   = 4'd1,
    PH_SR_NTPH   = 4'd2,
    PH_SR_NTPL   = 4'd3,
    PH_SR_RTP    = 4'd4,
    PH_SKIP      = 4'd5,
    PH_SDES_SSRC = 4'd6,
    PH_SDES_ITEM = 4'd7,
    PH_FIRST     = 4'd8
  } rcpp_phase_t;

  typedef struct packed {
    logic [17:0] sub_bytes_left;
    logic [4:0]  sub_count;
    rcpp_phase_t field_phase;
    logic [15:0] skip_words;
  } rcpp_walk_t;

  typedef struct packed {
    logic        result_kind;
    logic [31:0] sender_ssrc;
    logic [31:0] ntp_high;
    logic [31:0] ntp_low;
    logic [31:0] rtp_stamp;
    logic [10:0] received_size;
    logic        accepted;
    logic        last_of_run;
  } rcpp_result_t;

  typedef struct packed {
    logic [1:0]   count;
    rcpp_result_t res0;
    rcpp_result_t res1;
  } rcpp_push_t;

endpackage

`default_nettype wire

// ===== hw/rtl/rcpp_out_fifo.sv =====
// ----------------------------------------------------------------------------
// rcpp_out_fifo: result item queue
// Four-entry queue taking up to two result items per cycle, one out per cycle while out_ready is high.
// ----------------------------------------------------------------------------
`default_nettype none

module rcpp_out_fifo (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire rcpp_pkg::rcpp_push_t  push,
  output logic                       room,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output rcpp_pkg::rcpp_result_t     out_item
);
  import rcpp_pkg::*;

  rcpp_result_t       mem [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [FIFO_AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [FIFO_AW:0]   count_r,  count_nxt;
  logic               pop;

  assign pop       = out_valid && out_ready;
  assign out_valid = (count_r != '0);
  assign out_item  = mem[rd_ptr_r];
  // two free slots needed: one word can yield two items
  assign room      = (count_r <= (FIFO_AW+1)'(FIFO_DEPTH - 2));

  always_comb begin
    wr_ptr_nxt = wr_ptr_r + FIFO_AW'(push.count);
    rd_ptr_nxt = rd_ptr_r + FIFO_AW'(pop);
    count_nxt  = count_r + (FIFO_AW+1)'(push.count) - (FIFO_AW+1)'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push.count != 2'd0) begin
      mem[wr_ptr_r] <= push.res0;
    end
    if (push.count == 2'd2) begin
      mem[wr_ptr_r + FIFO_AW'(1)] <= push.res1;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/rcpp_parse.sv =====
// ----------------------------------------------------------------------------
// rcpp_parse: packet word register and header walk
// Registers each word, walks the sub-packet headers and forms result items.
// ----------------------------------------------------------------------------
`default_nettype none

module rcpp_parse (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire logic [31:0]          in_word,
  input  wire logic                 in_first,
  input  wire logic                 in_final,
  input  wire logic [10:0]          in_bytes,
  input  wire logic                 cfg_wr_en,
  input  wire logic [7:0]           cfg_wr_data,
  input  wire logic                 room,
  output rcpp_pkg::rcpp_push_t      push
);
  import rcpp_pkg::*;

  // word register
  logic        vld_r;
  logic [31:0] word_r;
  logic        first_r;
  logic        final_r;
  logic [10:0] bytes_r;
  logic        fire;

  logic [7:0]  overhead_r;

  // walk state
  logic [10:0] bytes_left_r,  bytes_left_nxt;
  rcpp_walk_t  walk_r,        walk_nxt;
  logic [7:0]  sub_type_r,    sub_type_nxt;
  logic        stopped_r,     stopped_nxt;
  logic        header_ok_r,   header_ok_nxt;
  logic [31:0] last_ssrc_r,   last_ssrc_nxt;
  logic [31:0] ntp_high_r,    ntp_high_nxt;
  logic [31:0] ntp_low_r,     ntp_low_nxt;
  logic [10:0] size_held_r,   size_held_nxt;

  logic [10:0] rem;
  logic [17:0] len;
  logic [8:0]  item_size;
  logic        sr_emit;
  rcpp_result_t sr_res, sum_res;

  function automatic rcpp_walk_t end_sub(input rcpp_walk_t w);
    rcpp_walk_t o;
    o                = w;
    o.skip_words     = w.sub_bytes_left[17:2];
    o.sub_bytes_left = '0;
    o.sub_count      = '0;
    o.field_phase    = (o.skip_words != '0) ? PH_SKIP : PH_HEADER;
    return o;
  endfunction

  function automatic rcpp_walk_t next_chunk(input rcpp_walk_t w);
    rcpp_walk_t o;
    o = w;
    if (w.sub_count == '0 || w.sub_bytes_left < 18'd4) begin
      o = end_sub(w);
    end else begin
      o.sub_count      = w.sub_count - 5'd1;
      o.sub_bytes_left = w.sub_bytes_left - 18'd4;
      o.field_phase    = PH_SDES_SSRC;
    end
    return o;
  endfunction

  assign fire     = vld_r && room;
  assign in_ready = !vld_r || fire;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (in_ready) begin
      vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      word_r  <= in_word;
      first_r <= in_first;
      final_r <= in_final;
      bytes_r <= in_bytes;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      overhead_r <= OVERHEAD_RESET;
    end else if (cfg_wr_en) begin
      overhead_r <= cfg_wr_data;
    end
  end

  always_comb begin
    bytes_left_nxt = bytes_left_r;
    walk_nxt       = walk_r;
    sub_type_nxt   = sub_type_r;
    stopped_nxt    = stopped_r;
    header_ok_nxt  = header_ok_r;
    last_ssrc_nxt  = last_ssrc_r;
    ntp_high_nxt   = ntp_high_r;
    ntp_low_nxt    = ntp_low_r;
    size_held_nxt  = size_held_r;
    rem            = '0;
    len            = {word_r[15:0], 2'b00};
    item_size      = (9'd5 + {1'b0, word_r[23:16]}) & ~9'd3;
    sr_emit        = 1'b0;

    if (fire) begin
      if (first_r) begin
        bytes_left_nxt = (bytes_r > MAX_PACKET_BYTES) ? MAX_PACKET_BYTES : bytes_r;
        size_held_nxt  = bytes_left_nxt;
        walk_nxt       = '{sub_bytes_left: '0, sub_count: '0,
                           field_phase: PH_FIRST, skip_words: '0};
        sub_type_nxt   = '0;
        stopped_nxt    = 1'b0;
        header_ok_nxt  = 1'b0;
        last_ssrc_nxt  = '0;
        ntp_high_nxt   = '0;
        ntp_low_nxt    = '0;
      end

      if (!stopped_nxt) begin
        rem = bytes_left_nxt;
        if (rem < 11'd4) begin
          stopped_nxt = 1'b1;
        end else begin
          bytes_left_nxt = rem - 11'd4;
          case (walk_nxt.field_phase)
            PH_FIRST, PH_HEADER: begin
              if (walk_nxt.field_phase == PH_FIRST &&
                  (word_r & HDR_FIRST_MASK) != HDR_FIRST_VAL) begin
                stopped_nxt = 1'b1;
              end else if (walk_nxt.field_phase == PH_HEADER &&
                           (word_r & HDR_VER_MASK) != HDR_VER_VAL) begin
                stopped_nxt = 1'b1;
              end else if (len > {7'b0, rem - 11'd4}) begin
                if (walk_nxt.field_phase == PH_FIRST) begin
                  header_ok_nxt = 1'b1;
                end
                stopped_nxt = 1'b1;
              end else begin
                if (walk_nxt.field_phase == PH_FIRST) begin
                  header_ok_nxt = 1'b1;
                end
                sub_type_nxt            = word_r[23:16];
                walk_nxt.sub_count      = word_r[28:24];
                walk_nxt.sub_bytes_left = len;
                if (word_r[23:16] == PT_SR) begin
                  walk_nxt.sub_count = '0;
                  if (len < 18'd4) begin
                    walk_nxt = end_sub(walk_nxt);
                  end else begin
                    walk_nxt.sub_bytes_left = len - 18'd4;
                    walk_nxt.field_phase    = PH_SR_SSRC;
                  end
                end else if (word_r[23:16] == PT_SDES) begin
                  walk_nxt = next_chunk(walk_nxt);
                end else begin
                  walk_nxt = end_sub(walk_nxt);
                end
              end
            end
            PH_SR_SSRC: begin
              last_ssrc_nxt = word_r;
              if (walk_nxt.sub_bytes_left < SR_INFO_BYTES) begin
                walk_nxt = end_sub(walk_nxt);
              end else begin
                walk_nxt.sub_bytes_left = walk_nxt.sub_bytes_left - SR_INFO_BYTES;
                walk_nxt.field_phase    = PH_SR_NTPH;
              end
            end
            PH_SR_NTPH: begin
              ntp_high_nxt         = word_r;
              walk_nxt.field_phase = PH_SR_NTPL;
            end
            PH_SR_NTPL: begin
              ntp_low_nxt          = word_r;
              walk_nxt.field_phase = PH_SR_RTP;
            end
            PH_SR_RTP: begin
              sr_emit                 = 1'b1;
              // skip both report counts plus any report blocks
              walk_nxt.skip_words     = 16'd2 + walk_nxt.sub_bytes_left[17:2];
              walk_nxt.sub_bytes_left = '0;
              walk_nxt.sub_count      = '0;
              walk_nxt.field_phase    = PH_SKIP;
            end
            PH_SKIP: begin
              if (walk_nxt.skip_words != '0) begin
                walk_nxt.skip_words = walk_nxt.skip_words - 16'd1;
              end
              if (walk_nxt.skip_words == '0) begin
                walk_nxt = next_chunk(walk_nxt);
              end
            end
            PH_SDES_SSRC: begin
              last_ssrc_nxt = word_r;
              if (walk_nxt.sub_bytes_left < 18'd4) begin
                stopped_nxt = 1'b1;
              end else begin
                walk_nxt.field_phase = PH_SDES_ITEM;
              end
            end
            PH_SDES_ITEM: begin
              // stop the walk on an item that runs past its sub-packet
              if ({9'b0, item_size} > walk_nxt.sub_bytes_left) begin
                stopped_nxt = 1'b1;
              end else begin
                walk_nxt.sub_bytes_left = walk_nxt.sub_bytes_left - {9'b0, item_size};
                walk_nxt.skip_words     = {9'b0, item_size[8:2]} - 16'd1;
                if (walk_nxt.skip_words != '0) begin
                  walk_nxt.field_phase = PH_SKIP;
                end else begin
                  walk_nxt = next_chunk(walk_nxt);
                end
              end
            end
            default: begin
              stopped_nxt = 1'b1;
            end
          endcase
        end
      end

      if (final_r) begin
        stopped_nxt = 1'b1;
      end
    end
  end

  always_comb begin
    sr_res               = '0;
    sr_res.sender_ssrc   = last_ssrc_r;
    sr_res.ntp_high      = ntp_high_r;
    sr_res.ntp_low       = ntp_low_r;
    sr_res.rtp_stamp     = word_r;
    sr_res.last_of_run   = !final_r;

    sum_res               = '0;
    sum_res.result_kind   = 1'b1;
    sum_res.sender_ssrc   = header_ok_nxt ? last_ssrc_nxt : 32'd0;
    sum_res.received_size = size_held_nxt + {3'b0, overhead_r};
    sum_res.accepted      = header_ok_nxt;
    sum_res.last_of_run   = 1'b1;

    push       = '0;
    push.res0  = sr_emit ? sr_res : sum_res;
    push.res1  = sum_res;
    if (fire) begin
      push.count = {1'b0, sr_emit} + {1'b0, final_r};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bytes_left_r <= '0;
      walk_r       <= '{sub_bytes_left: '0, sub_count: '0,
                        field_phase: PH_HEADER, skip_words: '0};
      sub_type_r   <= '0;
      stopped_r    <= 1'b1;
      header_ok_r  <= 1'b0;
      last_ssrc_r  <= '0;
      ntp_high_r   <= '0;
      ntp_low_r    <= '0;
      size_held_r  <= '0;
    end else begin
      bytes_left_r <= bytes_left_nxt;
      walk_r       <= walk_nxt;
      sub_type_r   <= sub_type_nxt;
      stopped_r    <= stopped_nxt;
      header_ok_r  <= header_ok_nxt;
      last_ssrc_r  <= last_ssrc_nxt;
      ntp_high_r   <= ntp_high_nxt;
      ntp_low_r    <= ntp_low_nxt;
      size_held_r  <= size_held_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/rtcp_compound_packet_parser.sv =====
// ----------------------------------------------------------------------------
// rtcp_compound_packet_parser: RTCP compound packet header walk
// Checks the first header, walks sub-packets, reports SR fields and a summary.
// ----------------------------------------------------------------------------
// Takes one 32-bit packet word per cycle while the queue has room. Each word
// is held in a word register and parsed from there; its result items (an SR
// report on the RTP timestamp word, a summary on the final word) go into a
// four-entry result queue. The input accepts a word whenever the queue has
// two free entries; a word that yields both an SR report and a summary is read
// out as two items. cfg_wr_data sets the IP plus UDP overhead added to the
// summary size (reset 28).
`default_nettype none

module rtcp_compound_packet_parser (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_tvalid,
  output logic              in_tready,
  input  wire logic [47:0]  in_tdata,   // packet_word[31:0], packet_bytes[42:32]
  input  wire logic         in_tuser,   // first_word
  input  wire logic         in_tlast,   // final_word
  output logic              out_tvalid,
  input  wire logic         out_tready,
  output logic [143:0]      out_tdata,  // sender_ssrc[31:0], ntp_high[63:32],
                                        // ntp_low[95:64], rtp_stamp[127:96],
                                        // received_size[138:128], accepted[139]
  output logic              out_tuser,  // result_kind
  output logic              out_tlast,  // last_of_run
  input  wire logic         cfg_wr_en,
  input  wire logic [7:0]   cfg_wr_data
);
  import rcpp_pkg::*;

  rcpp_push_t   push;
  rcpp_result_t item;
  logic         room;

  rcpp_parse u_parse (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_tvalid),
    .in_ready    (in_tready),
    .in_word     (in_tdata[31:0]),
    .in_first    (in_tuser),
    .in_final    (in_tlast),
    .in_bytes    (in_tdata[42:32]),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .room        (room),
    .push        (push)
  );

  rcpp_out_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .room      (room),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_item  (item)
  );

  assign out_tdata = {4'b0, item.accepted, item.received_size, item.rtp_stamp,
                      item.ntp_low, item.ntp_high, item.sender_ssrc};
  assign out_tuser = item.result_kind;
  assign out_tlast = item.last_of_run;

endmodule

`default_nettype wire

// ===== tb/tb_rtcp_compound_packet_parser.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_rtcp_compound_packet_parser: self-checking bench for the RTCP header walk
// Runs a short table of hand-built packets (wrong headers, short and oversize
// lengths, SR, RR and SDES walks), then generated compound packets with random
// content and some corruption. A behavioral walker predicts the SR reports and
// end-of-packet summaries; the sender idles in bursts and the receiver stalls.
// ----------------------------------------------------------------------------

module tb_rtcp_compound_packet_parser;
  import rcpp_pkg::*;

  localparam logic [7:0] PT_RR  = 8'd201;
  localparam logic [7:0] PT_BYE = 8'd203;

  typedef enum logic [1:0] {RX_STEADY, RX_RANDOM, RX_SPARSE, RX_BLOCKY} rx_mode_t;

  // one packet word with its flags, plus an optional hand-typed summary
  typedef struct packed {
    logic [31:0] word;
    logic        first;
    logic        fin;
    logic [10:0] nbytes;
    logic        typed;
    logic [31:0] t_ssrc;
    logic [10:0] t_size;
    logic        t_acc;
  } word_row_t;

  localparam int DIR_ROWS = 27;
  localparam word_row_t DIR_TABLE [DIR_ROWS] = '{
    // no packet started: ignored, then a lone final word gives a held summary
    '{32'h80C8_0006, 1'b0, 1'b0, 11'd0,    1'b0, 32'h0, 11'd0,    1'b0},
    '{32'h1234_5678, 1'b0, 1'b1, 11'd0,    1'b1, 32'h0, 11'd28,   1'b0},
    // oversize length saturates; empty RR
    '{32'h80C9_0000, 1'b1, 1'b1, 11'd2047, 1'b1, 32'h0, 11'd1488, 1'b1},
    // short packet, padding bit in first header, overlong first length
    '{32'h80C8_0006, 1'b1, 1'b1, 11'd3,    1'b1, 32'h0, 11'd31,   1'b0},
    '{32'hA0C8_0000, 1'b1, 1'b1, 11'd4,    1'b1, 32'h0, 11'd32,   1'b0},
    '{32'h80C8_FFFF, 1'b1, 1'b1, 11'd8,    1'b1, 32'h0, 11'd36,   1'b1},
    // plain SR
    '{32'h80C8_0006, 1'b1, 1'b0, 11'd28,   1'b0, 32'h0, 11'd0,    1'b0},
    '{32'hFFFF_FFFF, 1'b0, 1'b0, 11'd0,    1'b0, 32'h0, 11'd0,    1'b0},
    '{32'hFFFF_FFFF, 1'b0, 1'b0, 11'd0,    1'b0, 32'h0, 11'd0,    1'b0},
    '{32'h0000_0000, 1'b0, 1'b0, 11'd0,    1'b0, 32'h0, 11'd0,    1'b0},
    '{32'hFFFF_FFFF, 1'b0, 1'b0, 11'd0,    1'b0, 32'h0, 11'd0,    1'b0},
    '{32'h0000_0001, 1'b0, 1'b0, 11'd0,    1'b0, 32'h0, 11'd0,    1'b0},
    '{32'h0000_0064, 1'b0, 1'b1, 11'd0,    1'b0, 32'h0, 11'd0,    1'b0},
    // RR, SDES with one chunk, then an SDES item that overruns its sub-packet
    '{32'h80C9_0001, 1'b1, 1'b0, 11'd40,   1'b0, 32'h0, 11'd0,    1'b0},
    '{32'h0BAD_BEEF, 1'b0, 1'b0, 11'd0,    1'b0, 32'h0, 11'd0,    1'b0},
    '{32'h81CA_0003, 1'b0, 1'b0, 11'd0,    1'b0, 32'h0, 11'd0,    1'b0},
    '{32'h5EC0_FFEE, 1'b0, 1'b0, 11'd0,    1'b0, 32'h0, 11'd0,    1'b0},
    '{32'h0102_ABCD, 1'b0, 1'b0, 11'd0,    1'b0, 32'h0, 11'd0,    1'b0},
    '{32'h0000_0000, 1'b0, 1'b0, 11'd0,    1'b0, 32'h0, 11'd0,    1'b0},
    '{32'h81CA_0002, 1'b0, 1'b0, 11'd0,    1'b0, 32'h0, 11'd0,    1'b0},
    '{32'h1122_3344, 1'b0, 1'b0, 11'd0,    1'b0, 32'h0, 11'd0,    1'b0},
    '{32'h0108_0000, 1'b0, 1'b0, 11'd0,    1'b0, 32'h0, 11'd0,    1'b0},
    '{32'hDEAD_BEEF, 1'b0, 1'b1, 11'd0,    1'b0, 32'h0, 11'd0,    1'b0},
    // bad version in a later header
    '{32'h80C9_0000, 1'b1, 1'b0, 11'd8,    1'b0, 32'h0, 11'd0,    1'b0},
    '{32'h4000_0000, 1'b0, 1'b1, 11'd0,    1'b0, 32'h0, 11'd0,    1'b0},
    // word past the packet length
    '{32'h80C9_0000, 1'b1, 1'b0, 11'd4,    1'b0, 32'h0, 11'd0,    1'b0},
    '{32'h0000_FFFF, 1'b0, 1'b1, 11'd0,    1'b1, 32'h0, 11'd32,   1'b1}
  };

  logic         clk;
  logic         rst_n;
  logic         in_tvalid;
  logic         in_tready;
  logic [47:0]  in_tdata;
  logic         in_tuser;
  logic         in_tlast;
  logic         out_tvalid;
  logic         out_tready;
  logic [143:0] out_tdata;
  logic         out_tuser;
  logic         out_tlast;
  logic         cfg_wr_en;
  logic [7:0]   cfg_wr_data;

  rtcp_compound_packet_parser u_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .in_tlast    (in_tlast),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .out_tlast   (out_tlast),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  // walker state
  logic [7:0]  overhead_q;
  logic [10:0] room_bytes;
  logic [17:0] sub_room;
  logic [4:0]  chunks_left;
  rcpp_phase_t phase;
  logic [15:0] words_to_skip;
  logic        walk_halted;
  logic        first_hdr_ok;
  logic [31:0] seen_ssrc;
  logic [31:0] ntp_hi_q;
  logic [31:0] ntp_lo_q;
  logic [10:0] pkt_size_q;

  rcpp_result_t expected_reports[$];
  rcpp_result_t step_reports[$];
  word_row_t    packet_rows[$];
  int           mismatch_count;
  int           sent_items;
  int           burst_left;

  rx_mode_t     rx_mode;
  int           rx_mode_left;
  logic [3:0]   rx_tick;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #4_000_000;
    $display("tb_rtcp_compound_packet_parser NOT OK");
    $finish;
  end

  // receiver: switch at random between stall patterns
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready   <= 1'b0;
      rx_mode      <= RX_STEADY;
      rx_mode_left <= 64;
      rx_tick      <= '0;
    end else begin
      rx_tick <= rx_tick + 4'd1;
      if (rx_mode_left == 0) begin
        rx_mode      <= rx_mode_t'($urandom_range(0, 3));
        rx_mode_left <= $urandom_range(32, 256);
      end else begin
        rx_mode_left <= rx_mode_left - 1;
      end
      case (rx_mode)
        RX_STEADY: out_tready <= 1'b1;
        RX_RANDOM: out_tready <= ($urandom_range(0, 9) < 7);
        RX_SPARSE: out_tready <= (rx_tick[1:0] == 2'd0);
        default:   out_tready <= rx_tick[3];
      endcase
    end
  end

  task automatic check_field(input string name, input logic [31:0] want_v,
                             input logic [31:0] got_v);
    if (got_v !== want_v) begin
      $error("%s mismatch: expected %0h, got %0h", name, want_v, got_v);
      mismatch_count++;
    end
  endtask

  always @(posedge clk) begin
    rcpp_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_reports.size() == 0) begin
        $error("result item with nothing expected: kind %0d ssrc %0h",
               out_tuser, out_tdata[31:0]);
        mismatch_count++;
      end else begin
        want = expected_reports.pop_front();
        check_field("result_kind",   32'(want.result_kind),   32'(out_tuser));
        check_field("sender_ssrc",   want.sender_ssrc,        out_tdata[31:0]);
        check_field("ntp_high",      want.ntp_high,           out_tdata[63:32]);
        check_field("ntp_low",       want.ntp_low,            out_tdata[95:64]);
        check_field("rtp_stamp",     want.rtp_stamp,          out_tdata[127:96]);
        check_field("received_size", 32'(want.received_size), 32'(out_tdata[138:128]));
        check_field("accepted",      32'(want.accepted),      32'(out_tdata[139]));
        check_field("last_of_run",   32'(want.last_of_run),   32'(out_tlast));
      end
    end
  end

  // close the current sub-packet: skip whatever it still holds
  task automatic close_sub();
    words_to_skip = 16'(sub_room >> 2);
    sub_room      = '0;
    chunks_left   = '0;
    phase         = (words_to_skip != 0) ? PH_SKIP : PH_HEADER;
  endtask

  task automatic open_chunk();
    if (chunks_left == 0 || sub_room < 18'd4) begin
      close_sub();
    end else begin
      chunks_left = chunks_left - 5'd1;
      sub_room    = sub_room - 18'd4;
      phase       = PH_SDES_SSRC;
    end
  endtask

  task automatic walk_rtcp_word(input logic [31:0] w, input logic [10:0] r);
    int unsigned len;
    int unsigned isize;
    rcpp_result_t rep;
    case (phase)
      PH_FIRST, PH_HEADER: begin
        if (phase == PH_FIRST) begin
          if ((w & HDR_FIRST_MASK) != HDR_FIRST_VAL) begin
            walk_halted = 1'b1;
            return;
          end
          first_hdr_ok = 1'b1;
        end else if ((w & HDR_VER_MASK) != HDR_VER_VAL) begin
          walk_halted = 1'b1;
          return;
        end
        len = 32'(w[15:0]) * 4;
        if (len > 32'(r) - 32'd4) begin
          walk_halted = 1'b1;
          return;
        end
        chunks_left = w[28:24];
        sub_room    = 18'(len);
        if (w[23:16] == PT_SR) begin
          chunks_left = '0;
          if (len < 4) begin
            close_sub();
          end else begin
            sub_room = sub_room - 18'd4;
            phase    = PH_SR_SSRC;
          end
        end else if (w[23:16] == PT_SDES) begin
          open_chunk();
        end else begin
          close_sub();
        end
      end
      PH_SR_SSRC: begin
        seen_ssrc = w;
        if (sub_room < SR_INFO_BYTES) begin
          close_sub();
        end else begin
          sub_room = sub_room - SR_INFO_BYTES;
          phase    = PH_SR_NTPH;
        end
      end
      PH_SR_NTPH: begin
        ntp_hi_q = w;
        phase    = PH_SR_NTPL;
      end
      PH_SR_NTPL: begin
        ntp_lo_q = w;
        phase    = PH_SR_RTP;
      end
      PH_SR_RTP: begin
        rep             = '0;
        rep.sender_ssrc = seen_ssrc;
        rep.ntp_high    = ntp_hi_q;
        rep.ntp_low     = ntp_lo_q;
        rep.rtp_stamp   = w;
        step_reports.push_back(rep);
        // skip the two counts and any report blocks
        words_to_skip = 16'(32'd2 + 32'(sub_room >> 2));
        sub_room      = '0;
        chunks_left   = '0;
        phase         = PH_SKIP;
      end
      PH_SKIP: begin
        if (words_to_skip != 0) words_to_skip = words_to_skip - 16'd1;
        if (words_to_skip == 0) open_chunk();
      end
      PH_SDES_SSRC: begin
        seen_ssrc = w;
        if (sub_room < 18'd4) begin
          walk_halted = 1'b1;
          return;
        end
        phase = PH_SDES_ITEM;
      end
      PH_SDES_ITEM: begin
        isize = (32'd5 + 32'(w[23:16])) & ~32'd3;
        if (isize > 32'(sub_room)) begin
          walk_halted = 1'b1;
          return;
        end
        sub_room      = sub_room - 18'(isize);
        words_to_skip = 16'(isize / 4 - 1);
        if (words_to_skip != 0) phase = PH_SKIP;
        else open_chunk();
      end
      default: walk_halted = 1'b1;
    endcase
  endtask

  // predict the result items of one accepted word into step_reports
  task automatic predict_rtcp_item(input word_row_t row);
    logic [10:0] nb;
    logic [10:0] r;
    rcpp_result_t summ;
    step_reports.delete();
    if (row.first) begin
      nb            = (row.nbytes > MAX_PACKET_BYTES) ? MAX_PACKET_BYTES : row.nbytes;
      room_bytes    = nb;
      pkt_size_q    = nb;
      sub_room      = '0;
      chunks_left   = '0;
      words_to_skip = '0;
      phase         = PH_FIRST;
      walk_halted   = 1'b0;
      first_hdr_ok  = 1'b0;
      seen_ssrc     = '0;
      ntp_hi_q      = '0;
      ntp_lo_q      = '0;
    end
    if (!walk_halted) begin
      r = room_bytes;
      if (r < 11'd4) begin
        walk_halted = 1'b1;
      end else begin
        room_bytes = r - 11'd4;
        walk_rtcp_word(row.word, r);
      end
    end
    if (row.fin) begin
      summ               = '0;
      summ.result_kind   = 1'b1;
      summ.sender_ssrc   = first_hdr_ok ? seen_ssrc : 32'h0;
      summ.received_size = 11'(pkt_size_q + 11'(overhead_q));
      summ.accepted      = first_hdr_ok;
      step_reports.push_back(summ);
      walk_halted = 1'b1;
    end
    if (step_reports.size() != 0) step_reports[step_reports.size() - 1].last_of_run = 1'b1;
  endtask

  task automatic send_word(input word_row_t row);
    rcpp_result_t typed_rep;
    if (burst_left == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 200)
                                                : $urandom_range(1, 24);
    end
    burst_left--;
    in_tvalid <= 1'b1;
    in_tdata  <= {5'd0, row.nbytes, row.word};
    in_tuser  <= row.first;
    in_tlast  <= row.fin;
    do @(posedge clk); while (!in_tready);
    predict_rtcp_item(row);
    sent_items++;
    if (row.typed) begin
      typed_rep               = '0;
      typed_rep.result_kind   = 1'b1;
      typed_rep.sender_ssrc   = row.t_ssrc;
      typed_rep.received_size = row.t_size;
      typed_rep.accepted      = row.t_acc;
      typed_rep.last_of_run   = 1'b1;
      expected_reports.push_back(typed_rep);
    end else begin
      foreach (step_reports[i]) expected_reports.push_back(step_reports[i]);
    end
  endtask

  // stop sending and hold until every expected item is out and the pipe is empty
  task automatic drain_results();
    in_tvalid <= 1'b0;
    while (expected_reports.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  task automatic write_overhead(input logic [7:0] value);
    drain_results();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    overhead_q  = value;
  endtask

  // build one compound packet into packet_rows
  task automatic build_packet();
    logic [31:0] body[$];
    int unsigned hdr_at[$];
    int unsigned nsub, cnt, ilen, isz, hpos, nbytes;
    int          fin_at;
    logic [7:0]  pt;
    word_row_t   row;
    packet_rows.delete();
    if ($urandom_range(0, 19) == 0) begin
      // noise: loose words with random flags
      repeat ($urandom_range(1, 6)) begin
        row        = '0;
        row.word   = $urandom;
        row.first  = ($urandom_range(0, 3) == 0);
        row.fin    = ($urandom_range(0, 3) == 0);
        row.nbytes = $urandom_range(0, 2047);
        packet_rows.push_back(row);
      end
      return;
    end
    nsub = $urandom_range(1, 4);
    for (int s = 0; s < nsub; s++) begin
      hpos = body.size();
      hdr_at.push_back(hpos);
      body.push_back(32'h0);
      if (s == 0) begin
        pt = $urandom_range(0, 1) ? PT_SR : PT_RR;
      end else begin
        case ($urandom_range(0, 5))
          0:       pt = PT_SR;
          1:       pt = PT_RR;
          2, 3:    pt = PT_SDES;
          4:       pt = PT_BYE;
          default: pt = 8'($urandom_range(0, 255));
        endcase
      end
      if (pt == PT_SR) begin
        cnt = $urandom_range(0, 1);
        repeat (6 + 6 * cnt + $urandom_range(0, 1)) body.push_back($urandom);
      end else if (pt == PT_RR) begin
        cnt = $urandom_range(0, 1);
        repeat (1 + 6 * cnt) body.push_back($urandom);
      end else if (pt == PT_SDES) begin
        cnt = $urandom_range(0, 2);
        repeat (cnt) begin
          ilen = $urandom_range(0, 12);
          isz  = (ilen + 5) & ~32'd3;
          body.push_back($urandom);
          body.push_back({8'($urandom_range(1, 8)), 8'(ilen), 16'($urandom)});
          repeat (isz / 4 - 1) body.push_back($urandom);
        end
      end else if (pt == PT_BYE) begin
        cnt = $urandom_range(0, 2);
        repeat (cnt) body.push_back($urandom);
      end else begin
        cnt = $urandom_range(0, 31);
        repeat ($urandom_range(0, 3)) body.push_back($urandom);
      end
      body[hpos] = {2'b10, 1'b0, 5'(cnt), pt, 16'(body.size() - hpos - 1)};
    end
    // corrupt some packets: a header bit or any bit
    if ($urandom_range(0, 4) == 0) begin
      if ($urandom_range(0, 1)) begin
        hpos = hdr_at[$urandom_range(0, hdr_at.size() - 1)];
      end else begin
        hpos = $urandom_range(0, body.size() - 1);
      end
      body[hpos][$urandom_range(0, 31)] ^= 1'b1;
    end
    nbytes = body.size() * 4;
    case ($urandom_range(0, 9))
      0:       nbytes = $urandom_range(0, 2047);
      1:       nbytes = (nbytes > 8) ? nbytes - 4 * $urandom_range(1, 2) : nbytes;
      default: ;
    endcase
    fin_at = body.size() - 1;
    case ($urandom_range(0, 9))
      0:       fin_at = -1;
      1:       repeat ($urandom_range(1, 2)) body.push_back($urandom);
      default: ;
    endcase
    foreach (body[i]) begin
      row        = '0;
      row.word   = body[i];
      row.first  = (i == 0);
      row.fin    = (i == fin_at);
      row.nbytes = (i == 0) ? 11'(nbytes) : 11'($urandom_range(0, 2047));
      packet_rows.push_back(row);
    end
  endtask

  initial begin
    logic [7:0] cfg_plan [4];
    int         next_cfg_at;
    int         cfg_step;
    rst_n        <= 1'b0;
    in_tvalid    <= 1'b0;
    in_tdata     <= '0;
    in_tuser     <= 1'b0;
    in_tlast     <= 1'b0;
    cfg_wr_en    <= 1'b0;
    cfg_wr_data  <= '0;
    overhead_q    = OVERHEAD_RESET;
    room_bytes    = '0;
    sub_room      = '0;
    chunks_left   = '0;
    phase         = PH_HEADER;
    words_to_skip = '0;
    walk_halted   = 1'b1;
    first_hdr_ok  = 1'b0;
    seen_ssrc     = '0;
    ntp_hi_q      = '0;
    ntp_lo_q      = '0;
    pkt_size_q    = '0;
    mismatch_count = 0;
    sent_items     = 0;
    burst_left     = 0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int i = 0; i < DIR_ROWS; i++) send_word(DIR_TABLE[i]);

    cfg_plan    = '{8'd0, 8'd255, 8'($urandom_range(1, 254)), 8'($urandom_range(0, 255))};
    cfg_step    = 0;
    next_cfg_at = sent_items;
    while (sent_items < 650) begin
      if (cfg_step < 4 && sent_items >= next_cfg_at) begin
        write_overhead(cfg_plan[cfg_step]);
        cfg_step++;
        next_cfg_at = sent_items + 150;
      end
      build_packet();
      foreach (packet_rows[i]) send_word(packet_rows[i]);
    end

    drain_results();
    repeat (4) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("tb_rtcp_compound_packet_parser OK");
    end else begin
      $display("tb_rtcp_compound_packet_parser NOT OK");
    end
    $finish;
  end

endmodule
